// ===== rtl/xpm_pkg.sv =====
// Shared types, constants and helpers for the palette pixel lookup.
package xpm_pkg;

  // Fixed field widths
  localparam int CODE_W    = 32;
  localparam int RGB_W     = 24;
  localparam int COLOR_W   = 8;
  localparam int CPP_W     = 3;
  localparam int COUNT_W   = 5;
  localparam int IDX_IN_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Widest code compared, in characters
  localparam int MAX_CODE_CHARS = 4;

  // Transaction function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARS_PER_PIXEL = 2'd0,
    CFG_COLOR_COUNT     = 2'd1,
    CFG_NONE_COLOR      = 2'd2
  } cfg_idx_t;

  // Byte mask of the code characters that take part in a compare
  function automatic logic [CODE_W-1:0] code_mask(input logic [CPP_W-1:0] cpp);
    int                n;
    logic [CODE_W-1:0] m;
    n = int'(cpp);
    if (n == 0) n = 1;
    if (n > MAX_CODE_CHARS) n = MAX_CODE_CHARS;
    m = '0;
    for (int b = 0; b < CODE_W / 8; b++) begin
      if (b < n) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ===== rtl/xpm_if.sv =====
// Channel interfaces: pixel/load input, pixel result output, register write.
interface xpm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [xpm_pkg::IDX_IN_W-1:0]  entry_index;
  logic [xpm_pkg::CODE_W-1:0]    pixel_code;
  logic [xpm_pkg::COLOR_W-1:0]   red_in;
  logic [xpm_pkg::COLOR_W-1:0]   green_in;
  logic [xpm_pkg::COLOR_W-1:0]   blue_in;
  logic                          no_color;

  modport source (output valid, func, entry_index, pixel_code, red_in, green_in, blue_in,
                  no_color, input ready);
  modport sink   (input valid, func, entry_index, pixel_code, red_in, green_in, blue_in,
                  no_color, output ready);
endinterface

interface xpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [xpm_pkg::COLOR_W-1:0] blue_out;
  logic [xpm_pkg::COLOR_W-1:0] green_out;
  logic [xpm_pkg::COLOR_W-1:0] red_out;
  logic [xpm_pkg::COLOR_W-1:0] alpha_out;
  logic                        matched;

  modport source (output valid, blue_out, green_out, red_out, alpha_out, matched,
                  input ready);
  modport sink   (input valid, blue_out, green_out, red_out, alpha_out, matched,
                  output ready);
endinterface

interface xpm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [xpm_pkg::CFG_IDX_W-1:0] index;
  logic [xpm_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/xpm_palette_pixel_lookup.sv =====
// Top level of the palette pixel lookup: palette store and lookup pipeline.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    func, entry_index, pixel_code, red/green/blue_in, no_color
//   out_ch   out  valid / ready    blue/green/red/alpha_out, matched
//   cfg_ch   in   valid / ready    index, data
//
// One transaction enters per cycle unless a result is stalled at out_ch; a pixel result passes
// the compare, priority-encode and color-read stages, the last loading the output register.
// Load transactions write the code store in the compare stage and the color store in
// the color-read stage, so every pixel sees exactly the loads accepted before it.
// Synchronous active-low reset sets configuration defaults and clears valid bits; palette
// contents are undefined until loaded. The whole pipeline holds while a result waits on out_ch;
// cfg_ch is always ready.
module xpm_palette_pixel_lookup #(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  xpm_in_if.sink     in_ch,
  xpm_out_if.source  out_ch,
  xpm_cfg_if.sink    cfg_ch
);

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Configuration registers
  logic [xpm_pkg::CPP_W-1:0]   cfg_cpp_r;
  logic [xpm_pkg::COUNT_W-1:0] cfg_count_r;
  logic [xpm_pkg::RGB_W-1:0]   cfg_none_r;

  // Palette store
  logic [xpm_pkg::CODE_W-1:0] code_tab_r [PALETTE_DEPTH];
  logic [xpm_pkg::RGB_W-1:0]  rgb_tab_r  [PALETTE_DEPTH];
  logic                       none_tab_r [PALETTE_DEPTH];

  // Stage 1: accepted transaction
  logic                          s1_vld_r;
  logic                          s1_func_r;
  logic [xpm_pkg::IDX_IN_W-1:0]  s1_idx_r;
  logic [xpm_pkg::CODE_W-1:0]    s1_code_r;
  logic [xpm_pkg::RGB_W-1:0]     s1_rgb_r;
  logic                          s1_none_r;

  // Stage 2: match vector
  logic                          s2_vld_r;
  logic                          s2_func_r;
  logic [xpm_pkg::IDX_IN_W-1:0]  s2_idx_r;
  logic [xpm_pkg::RGB_W-1:0]     s2_rgb_r;
  logic                          s2_none_r;
  logic [PALETTE_DEPTH-1:0]      s2_match_r;
  logic [PALETTE_DEPTH-1:0]      s2_match_nxt;

  // Stage 3: winning entry
  logic                          s3_vld_r;
  logic                          s3_func_r;
  logic [xpm_pkg::IDX_IN_W-1:0]  s3_idx_r;
  logic [xpm_pkg::RGB_W-1:0]     s3_rgb_r;
  logic                          s3_none_r;
  logic                          s3_hit_r;
  logic                          s3_hit_nxt;
  logic [IDX_W-1:0]              s3_sel_r;
  logic [IDX_W-1:0]              s3_sel_nxt;

  // Output register
  logic                          out_vld_r;
  logic                          out_hit_r;
  logic [xpm_pkg::RGB_W-1:0]     out_rgb_r;
  logic [xpm_pkg::RGB_W-1:0]     out_rgb_nxt;

  logic                          adv;
  logic [xpm_pkg::CODE_W-1:0]    mask;
  logic                          s1_load_wr;
  logic                          s3_load_wr;

  // Advance the whole pipeline unless a result is stalled at the output
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  assign mask = xpm_pkg::code_mask(cfg_cpp_r);

  assign s1_load_wr = adv && s1_vld_r && (s1_func_r == xpm_pkg::FUNC_LOAD) &&
                      (32'(s1_idx_r) < 32'(PALETTE_DEPTH));
  assign s3_load_wr = adv && s3_vld_r && (s3_func_r == xpm_pkg::FUNC_LOAD) &&
                      (32'(s3_idx_r) < 32'(PALETTE_DEPTH));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cpp_r   <= xpm_pkg::CPP_W'(1);
      cfg_count_r <= xpm_pkg::COUNT_W'(1);
      cfg_none_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        xpm_pkg::CFG_CHARS_PER_PIXEL: cfg_cpp_r   <= cfg_ch.data[xpm_pkg::CPP_W-1:0];
        xpm_pkg::CFG_COLOR_COUNT:     cfg_count_r <= cfg_ch.data[xpm_pkg::COUNT_W-1:0];
        xpm_pkg::CFG_NONE_COLOR:      cfg_none_r  <= cfg_ch.data[xpm_pkg::RGB_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare the pixel code with every entry in use
  always_comb begin
    for (int k = 0; k < PALETTE_DEPTH; k++) begin
      s2_match_nxt[k] = (((code_tab_r[k] ^ s1_code_r) & mask) == '0) &&
                        (32'(k) < 32'(cfg_count_r));
    end
  end

  // Pick the lowest matching entry
  always_comb begin
    s3_hit_nxt = 1'b0;
    s3_sel_nxt = '0;
    for (int k = PALETTE_DEPTH - 1; k >= 0; k--) begin
      if (s2_match_r[k]) begin
        s3_hit_nxt = 1'b1;
        s3_sel_nxt = IDX_W'(k);
      end
    end
  end

  // Read the winning entry's color
  always_comb begin
    if (!s3_hit_r) begin
      out_rgb_nxt = '0;
    end else if (none_tab_r[s3_sel_r]) begin
      out_rgb_nxt = cfg_none_r;
    end else begin
      out_rgb_nxt = rgb_tab_r[s3_sel_r];
    end
  end

  // Code store: written as a load leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_load_wr) begin
      code_tab_r[IDX_W'(s1_idx_r)] <= s1_code_r;
    end
  end

  // Color store: written as a load leaves stage 3
  always_ff @(posedge clk) begin
    if (s3_load_wr) begin
      rgb_tab_r[IDX_W'(s3_idx_r)]  <= s3_rgb_r;
      none_tab_r[IDX_W'(s3_idx_r)] <= s3_none_r;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_ch.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r && (s3_func_r == xpm_pkg::FUNC_PIXEL);
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r  <= in_ch.func;
      s1_idx_r   <= in_ch.entry_index;
      s1_code_r  <= in_ch.pixel_code;
      s1_rgb_r   <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
      s1_none_r  <= in_ch.no_color;

      s2_func_r  <= s1_func_r;
      s2_idx_r   <= s1_idx_r;
      s2_rgb_r   <= s1_rgb_r;
      s2_none_r  <= s1_none_r;
      s2_match_r <= s2_match_nxt;

      s3_func_r  <= s2_func_r;
      s3_idx_r   <= s2_idx_r;
      s3_rgb_r   <= s2_rgb_r;
      s3_none_r  <= s2_none_r;
      s3_hit_r   <= s3_hit_nxt;
      s3_sel_r   <= s3_sel_nxt;

      out_hit_r  <= s3_hit_r;
      out_rgb_r  <= out_rgb_nxt;
    end
  end

  // Drive the result channel
  assign out_ch.valid     = out_vld_r;
  assign out_ch.blue_out  = out_rgb_r[7:0];
  assign out_ch.green_out = out_rgb_r[15:8];
  assign out_ch.red_out   = out_rgb_r[23:16];
  assign out_ch.alpha_out = '0;
  assign out_ch.matched   = out_hit_r;

endmodule
